/* rtl/slr_pkg.sv */
// Shared types and constants of the stereo linear resampler.
`timescale 1ns / 1ps
package slr_pkg;

	localparam int STEP_W = 23;
	localparam logic [STEP_W-1:0] STEP_RESET = 23'd65536;

	localparam int MAX_RUN = 64;
	localparam int RUN_W = $clog2(MAX_RUN);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = 1'd1;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_FRAME,
		CMD_END
	} cmd_kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_ratio;
		logic              mono_source;
	} cfg_t;

endpackage

/* rtl/slr_ifs.sv */
// Valid/ready channel interfaces for source frames and result frames.
`timescale 1ns / 1ps
interface slr_frame_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	logic                          end_of_stream;

	modport source(output valid, sample_left, sample_right, end_of_stream, input ready);
	modport sink(input valid, sample_left, sample_right, end_of_stream, output ready);
endinterface

interface slr_result_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic                          last_of_run;
	logic                          stream_ended;

	modport source(output valid, out_left, out_right, last_of_run, stream_ended, input ready);
	modport sink(input valid, out_left, out_right, last_of_run, stream_ended, output ready);
endinterface

/* rtl/stereo_linear_resampler.sv */
// A frame's first result passes the command queue, the run state of the sequencer,
// the stage-one register and the output register; an end item skips the run state.
// Throughput: one result per cycle while the result sink is ready; a frame yields
// at most 64 results, and the sequencer takes no new item while it issues them.
// Items are accepted in every cycle while the two-entry command queue has room.
// Reset clears the stream state, phase and queue; step_ratio resets to 1.0, mono to 0.
`timescale 1ns / 1ps
module stereo_linear_resampler #(
	parameter int FRAC_BITS   = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	slr_frame_if.sink                      frames,
	slr_result_if.source                   results,
	input  logic                           cfg_wr_en,
	input  logic [slr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slr_pkg::STEP_W-1:0]     cfg_data
);
	import slr_pkg::*;

	localparam int KIND_W = $bits(cmd_kind_t);
	localparam int CMD_W = KIND_W + 2 * SAMPLE_BITS;

	cfg_t                          cfg_q;
	logic                          push, q_full, q_empty, q_pop;
	cmd_kind_t                     push_kind, q_kind;
	logic signed [SAMPLE_BITS-1:0] push_left, push_right, q_left, q_right;
	logic [CMD_W-1:0]              push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ratio <= STEP_RESET;
			cfg_q.mono_source <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STEP_RATIO: cfg_q.step_ratio <= cfg_data;
				REG_MONO_SOURCE: cfg_q.mono_source <= cfg_data[0];
				default: ;
			endcase
		end
	end

	slr_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frames   (frames),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.cmd_kind (push_kind),
		.cmd_left (push_left),
		.cmd_right(push_right)
	);

	assign push_data = {push_kind, push_left, push_right};

	slr_cmd_queue #(
		.WIDTH(CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_data (pop_data)
	);

	assign q_kind = cmd_kind_t'(pop_data[CMD_W-1 -: KIND_W]);
	assign q_left = pop_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
	assign q_right = pop_data[SAMPLE_BITS-1:0];

	slr_back #(
		.FRAC_BITS  (FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_kind (q_kind),
		.q_left (q_left),
		.q_right(q_right),
		.q_pop  (q_pop),
		.results(results)
	);

endmodule

/* rtl/slr_front.sv */
// Front end: accepts source items, tracks start and end of stream, and issues commands.
`timescale 1ns / 1ps
module slr_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	slr_frame_if.sink                     frames,
	input  slr_pkg::cfg_t                 cfg,
	input  logic                          q_full,
	output logic                          push,
	output slr_pkg::cmd_kind_t            cmd_kind,
	output logic signed [SAMPLE_BITS-1:0] cmd_left,
	output logic signed [SAMPLE_BITS-1:0] cmd_right
);
	import slr_pkg::*;

	logic ended_q;
	logic primed_q;
	logic accept;

	assign frames.ready = !q_full;
	assign accept = frames.valid && frames.ready;
	assign push = accept && !ended_q;

	always_comb begin
		if (frames.end_of_stream) begin
			cmd_kind = CMD_END;
		end else if (!primed_q) begin
			cmd_kind = CMD_LOAD;
		end else begin
			cmd_kind = CMD_FRAME;
		end
	end

	assign cmd_left = frames.sample_left;
	assign cmd_right = cfg.mono_source ? frames.sample_left : frames.sample_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
			primed_q <= 1'b0;
		end else if (push) begin
			if (frames.end_of_stream) begin
				ended_q <= 1'b1;
			end else begin
				primed_q <= 1'b1;
			end
		end
	end

endmodule

/* rtl/slr_cmd_queue.sv */
// Two-entry command queue between the front end and the interpolation back end.
`timescale 1ns / 1ps
module slr_cmd_queue #(
	parameter int WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/slr_back.sv */
// Back end: phase sequencer and two-stage interpolation datapath with output register.
`timescale 1ns / 1ps
module slr_back #(
	parameter int FRAC_BITS   = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slr_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	input  slr_pkg::cmd_kind_t            q_kind,
	input  logic signed [SAMPLE_BITS-1:0] q_left,
	input  logic signed [SAMPLE_BITS-1:0] q_right,
	output logic                          q_pop,
	slr_result_if.source                  results
);
	import slr_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int S = SAMPLE_BITS;
	localparam int PH_W = ((STEP_W > F) ? STEP_W : F) + 1;
	localparam int T_W = S + F + 2;
	localparam logic [PH_W-1:0] ONE = PH_W'(1) << F;
	localparam logic signed [T_W-1:0] RBIAS = T_W'((64'd1 << F) - 64'd1);

	back_state_t          state_q, state_d;
	logic [PH_W-1:0]      phase_q, phase_d, phase_nx;
	logic [RUN_W-1:0]     cnt_q, cnt_d;
	logic signed [S-1:0]  prev_l_q, prev_l_d, prev_r_q, prev_r_d;
	logic signed [S-1:0]  new_l_q, new_l_d, new_r_q, new_r_d;

	logic                 en;
	logic                 iss_v, iss_end, iss_last;
	logic signed [S:0]    diff_l, diff_r;
	logic signed [F:0]    frac;
	logic signed [T_W-1:0] prod_l, prod_r;

	logic                 v_s1, last_s1, end_s1;
	logic signed [S-1:0]  a_l_s1, a_r_s1;
	logic signed [T_W-1:0] prod_l_s1, prod_r_s1;

	logic signed [T_W-1:0] t_l, t_r, r_l, r_r, sh_l, sh_r;

	logic                 out_v_q, out_last_q, out_end_q;
	logic signed [S-1:0]  out_l_q, out_r_q;

	assign en = !out_v_q || results.ready;
	assign phase_nx = phase_q + PH_W'(cfg.step_ratio);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d = cnt_q;
		prev_l_d = prev_l_q;
		prev_r_d = prev_r_q;
		new_l_d = new_l_q;
		new_r_d = new_r_q;
		q_pop = 1'b0;
		iss_v = 1'b0;
		iss_end = 1'b0;
		iss_last = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && en) begin
					q_pop = 1'b1;
					case (q_kind)
						CMD_LOAD: begin
							prev_l_d = q_left;
							prev_r_d = q_right;
						end
						CMD_END: begin
							iss_v = 1'b1;
							iss_end = 1'b1;
							iss_last = 1'b1;
						end
						CMD_FRAME: begin
							if (phase_q >= ONE) begin
								phase_d = phase_q - ONE;
								prev_l_d = q_left;
								prev_r_d = q_right;
							end else begin
								new_l_d = q_left;
								new_r_d = q_right;
								cnt_d = '0;
								state_d = BK_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			BK_RUN: begin
				if (en) begin
					iss_v = 1'b1;
					cnt_d = cnt_q + RUN_W'(1);
					if (phase_nx >= ONE || cnt_q == RUN_W'(MAX_RUN - 1)) begin
						iss_last = 1'b1;
						phase_d = (phase_nx >= ONE) ? (phase_nx - ONE) : '0;
						prev_l_d = new_l_q;
						prev_r_d = new_r_q;
						state_d = BK_IDLE;
					end else begin
						phase_d = phase_nx;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			phase_q <= '0;
			cnt_q <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			new_l_q <= '0;
			new_r_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			prev_l_q <= prev_l_d;
			prev_r_q <= prev_r_d;
			new_l_q <= new_l_d;
			new_r_q <= new_r_d;
		end
	end

	// Difference times fraction; the fraction is below 1.0 whenever a result issues.
	assign frac = $signed({1'b0, phase_q[F-1:0]});
	assign diff_l = {new_l_q[S-1], new_l_q} - {prev_l_q[S-1], prev_l_q};
	assign diff_r = {new_r_q[S-1], new_r_q} - {prev_r_q[S-1], prev_r_q};
	assign prod_l = T_W'(diff_l) * T_W'(frac);
	assign prod_r = T_W'(diff_r) * T_W'(frac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= iss_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= iss_last;
			end_s1 <= iss_end;
			a_l_s1 <= iss_end ? '0 : prev_l_q;
			a_r_s1 <= iss_end ? '0 : prev_r_q;
			prod_l_s1 <= iss_end ? '0 : prod_l;
			prod_r_s1 <= iss_end ? '0 : prod_r;
		end
	end

	// Add the scaled base sample, then shift with truncation toward zero.
	always_comb begin
		t_l = (T_W'(a_l_s1) <<< F) + prod_l_s1;
		t_r = (T_W'(a_r_s1) <<< F) + prod_r_s1;
		r_l = t_l + (t_l[T_W-1] ? RBIAS : '0);
		r_r = t_r + (t_r[T_W-1] ? RBIAS : '0);
		sh_l = r_l >>> F;
		sh_r = r_r >>> F;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_l_q <= sh_l[S-1:0];
			out_r_q <= sh_r[S-1:0];
			out_last_q <= last_s1;
			out_end_q <= end_s1;
		end
	end

	assign results.valid = out_v_q;
	assign results.out_left = out_l_q;
	assign results.out_right = out_r_q;
	assign results.last_of_run = out_last_q;
	assign results.stream_ended = out_end_q;

endmodule

/* verif/stereo_linear_resampler_tb.sv */
// Self-checking testbench of the stereo linear resampler: directed table, then random frames.
`timescale 1ns / 1ps
module stereo_linear_resampler_tb;
	import slr_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int SAMPLE_BITS = 16;
	localparam logic [31:0] PHASE_ONE = 32'd1 << FRAC_BITS;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTINGS_PER_MODE = 4;
	localparam int FRAMES_PER_SETTING = 25;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp_l;
		logic signed [SAMPLE_BITS-1:0] smp_r;
		logic                          last;
		logic                          done;
	} out_frame_t;

	typedef enum logic [1:0] {
		ROW_FRAME,
		ROW_STEP,
		ROW_MONO
	} row_kind_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} row_chk_t;

	typedef struct packed {
		row_kind_t                     kind;
		row_chk_t                      chk;
		logic [STEP_W-1:0]             val;
		logic signed [SAMPLE_BITS-1:0] sl;
		logic signed [SAMPLE_BITS-1:0] sr;
		out_frame_t                    want;
	} row_t;

	localparam out_frame_t NO_WANT = '0;
	localparam int N_ROWS = 24;

	row_t directed_rows [0:N_ROWS-1] = '{
		'{ROW_FRAME, CHK_NONE, 23'd0, 16'sh7fff, 16'sh8000, NO_WANT},
		'{ROW_FRAME, CHK_ONE, 23'd0, 16'sh8000, 16'sh7fff, '{16'sh7fff, 16'sh8000, 1'b1, 1'b0}},
		'{ROW_FRAME, CHK_ONE, 23'd0, 16'sh0000, 16'sh0000, '{16'sh8000, 16'sh7fff, 1'b1, 1'b0}},
		'{ROW_STEP, CHK_MODEL, 23'd32768, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh7fff, 16'sh8000, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'shffff, 16'sh0001, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh8000, 16'sh7fff, NO_WANT},
		'{ROW_MONO, CHK_MODEL, 23'd1, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh04d2, 16'sh0309, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh8000, 16'sh0005, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh7fff, 16'shffff, NO_WANT},
		'{ROW_MONO, CHK_MODEL, 23'h7ffffe, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_STEP, CHK_MODEL, 23'd1024, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh8000, 16'sh7fff, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh7fff, 16'sh8000, NO_WANT},
		'{ROW_STEP, CHK_MODEL, 23'd700, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh0064, 16'shff9c, NO_WANT},
		'{ROW_STEP, CHK_MODEL, 23'd0, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh0005, 16'shfffb, NO_WANT},
		'{ROW_STEP, CHK_MODEL, 23'h7fffff, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_STEP, CHK_MODEL, 23'd4194304, 16'sh0, 16'sh0, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh7fff, 16'sh7fff, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh8000, 16'sh8000, NO_WANT},
		'{ROW_FRAME, CHK_MODEL, 23'd0, 16'sh0001, 16'shffff, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STEP_W-1:0] cfg_data;

	slr_frame_if #(.SAMPLE_BITS(SAMPLE_BITS)) frames_if ();
	slr_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) results_if ();

	stereo_linear_resampler #(
		.FRAC_BITS(FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_if),
		.results(results_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state and its copy of the registers.
	logic signed [SAMPLE_BITS-1:0] hist_l;
	logic signed [SAMPLE_BITS-1:0] hist_r;
	logic [31:0] phase_acc;
	bit seen_frame;
	bit stream_done;
	logic [STEP_W-1:0] step_reg;
	logic mono_reg;

	out_frame_t item_outputs[$];
	out_frame_t awaited_outputs[$];

	int src_idle_pct;
	int sink_idle_pct;
	int errors = 0;
	int items_sent;
	int outputs_checked = 0;
	int reg_writes;
	int stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] interp_trunc(
			input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b,
			input logic [31:0] frac);
		longint acc;
		longint mag;
		acc = (longint'(a) <<< FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(frac);
		mag = (acc < 0) ? -acc : acc;
		mag = mag >>> FRAC_BITS;
		if (acc < 0)
			mag = -mag;
		return mag[SAMPLE_BITS-1:0];
	endfunction

	function automatic void resample_item(input logic signed [SAMPLE_BITS-1:0] sl,
			input logic signed [SAMPLE_BITS-1:0] sr, input logic eos);
		logic signed [SAMPLE_BITS-1:0] nl;
		logic signed [SAMPLE_BITS-1:0] nr;
		out_frame_t o;
		int n;
		item_outputs.delete();
		if (stream_done)
			return;
		if (eos) begin
			stream_done = 1'b1;
			o = '{'0, '0, 1'b1, 1'b1};
			item_outputs.push_back(o);
			return;
		end
		nl = sl;
		nr = mono_reg ? sl : sr;
		if (!seen_frame) begin
			seen_frame = 1'b1;
			hist_l = nl;
			hist_r = nr;
			return;
		end
		n = 0;
		while (phase_acc < PHASE_ONE && n < MAX_RUN) begin
			o.smp_l = interp_trunc(hist_l, nl, phase_acc);
			o.smp_r = interp_trunc(hist_r, nr, phase_acc);
			o.last = 1'b0;
			o.done = 1'b0;
			item_outputs.push_back(o);
			phase_acc = phase_acc + step_reg;
			n++;
		end
		if (n > 0) begin
			o = item_outputs.pop_back();
			o.last = 1'b1;
			item_outputs.push_back(o);
		end
		phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : 32'd0;
		hist_l = nl;
		hist_r = nr;
	endfunction

	// Returns in the time step of acceptance with valid still high.
	task automatic send_source(input logic signed [SAMPLE_BITS-1:0] sl,
			input logic signed [SAMPLE_BITS-1:0] sr, input logic eos, input bit use_model);
		while ($urandom_range(99) < src_idle_pct) begin
			frames_if.valid <= 1'b0;
			@(posedge clk);
		end
		frames_if.valid <= 1'b1;
		frames_if.sample_left <= sl;
		frames_if.sample_right <= sr;
		frames_if.end_of_stream <= eos;
		@(posedge clk);
		while (!frames_if.ready)
			@(posedge clk);
		items_sent++;
		resample_item(sl, sr, eos);
		if (use_model)
			foreach (item_outputs[k])
				awaited_outputs.push_back(item_outputs[k]);
	endtask

	task automatic settle();
		frames_if.valid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_STEP_RATIO)
			step_reg = data;
		else
			mono_reg = data[0];
		reg_writes++;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Mostly upsampling; strong downsampling is rare since the phase drains one frame at a time.
	function automatic logic [STEP_W-1:0] rand_step();
		case ($urandom_range(11))
			0: return 23'd1024;
			1: return 23'd65536;
			2: return STEP_W'($urandom_range(1023));
			3, 4, 5: return STEP_W'($urandom_range(16383, 1024));
			6, 7, 8: return STEP_W'($urandom_range(65535, 16384));
			9, 10: return STEP_W'($urandom_range(262143, 65537));
			default: return STEP_W'($urandom_range(4194304, 262144));
		endcase
	endfunction

	always @(posedge clk) begin : check_outputs
		out_frame_t got;
		out_frame_t want;
		results_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		if (results_if.valid && results_if.ready) begin
			got.smp_l = results_if.out_left;
			got.smp_r = results_if.out_right;
			got.last = results_if.last_of_run;
			got.done = results_if.stream_ended;
			if (awaited_outputs.size() == 0) begin
				errors++;
				$display("%0t: unexpected output L=%0d R=%0d last=%0b ended=%0b", $time,
					got.smp_l, got.smp_r, got.last, got.done);
			end else begin
				want = awaited_outputs.pop_front();
				outputs_checked++;
				if (got.smp_l !== want.smp_l || got.smp_r !== want.smp_r ||
						got.last !== want.last || got.done !== want.done) begin
					errors++;
					$display("%0t: mismatch, expected L=%0d R=%0d last=%0b ended=%0b, got L=%0d R=%0d last=%0b ended=%0b",
						$time, want.smp_l, want.smp_r, want.last, want.done,
						got.smp_l, got.smp_r, got.last, got.done);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d outputs still awaited", $time,
				STALL_LIMIT, awaited_outputs.size());
			$display("** stereo_linear_resampler: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_STEP_RATIO;
		cfg_data <= '0;
		frames_if.valid <= 1'b0;
		frames_if.sample_left <= '0;
		frames_if.sample_right <= '0;
		frames_if.end_of_stream <= 1'b0;
		hist_l = '0;
		hist_r = '0;
		phase_acc = '0;
		seen_frame = 1'b0;
		stream_done = 1'b0;
		step_reg = STEP_RESET;
		mono_reg = 1'b0;
		items_sent = 0;
		reg_writes = 0;
		src_idle_pct = 9;
		sink_idle_pct = 54;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_STEP: begin
					settle();
					write_reg(REG_STEP_RATIO, directed_rows[i].val);
				end
				ROW_MONO: begin
					settle();
					write_reg(REG_MONO_SOURCE, directed_rows[i].val);
				end
				default: begin
					send_source(directed_rows[i].sl, directed_rows[i].sr, 1'b0,
						directed_rows[i].chk == CHK_MODEL);
					if (directed_rows[i].chk == CHK_ONE)
						awaited_outputs.push_back(directed_rows[i].want);
				end
			endcase
		end

		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 54 : 0;
			sink_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 9 : 0;
			for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
				settle();
				write_reg(REG_STEP_RATIO, rand_step());
				write_reg(REG_MONO_SOURCE, STEP_W'($urandom));
				for (int k = 0; k < FRAMES_PER_SETTING; k++)
					send_source(rand_sample(), rand_sample(), 1'b0, 1'b1);
			end
		end

		// The end item closes the stream; everything after it must be dropped silently.
		send_source(rand_sample(), rand_sample(), 1'b1, 1'b0);
		awaited_outputs.push_back('{'0, '0, 1'b1, 1'b1});
		for (int k = 0; k < 3; k++)
			send_source(rand_sample(), rand_sample(), 1'b0, 1'b1);
		send_source(rand_sample(), rand_sample(), 1'b1, 1'b1);
		settle();

		$display("Sent %0d items over %0d register writes and three idling patterns,",
			items_sent, reg_writes);
		$display("checked %0d outputs, %0d errors.", outputs_checked, errors);
		if (errors == 0)
			$display("** stereo_linear_resampler: PASSED **");
		else
			$display("** stereo_linear_resampler: FAILED **");
		$finish;
	end

endmodule
